/* src/local_frame_deframer_assert.svh */
// Assertion macros for the frame deframer modules; used by lfd_parser.
// Depends on signals named clock and reset in the module that uses them.
`ifndef LOCAL_FRAME_DEFRAMER_ASSERT_SVH
`define LOCAL_FRAME_DEFRAMER_ASSERT_SVH

// Implication checked in the same cycle.
`define LFD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the next cycle.
`define LFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/lfd_pkg.sv */
// Types and constants for the local frame deframer.
// No dependencies; used by every module of the block.
package lfd_pkg;

   // Frame layout.
   localparam int unsigned ID_BYTES    = 2;
   localparam int unsigned ID_W        = 8 * ID_BYTES;
   localparam int unsigned POS_W       = 9;
   localparam int unsigned P_START     = 0;
   localparam int unsigned P_VER       = 1;
   localparam int unsigned P_SEQ       = 2;
   localparam int unsigned P_SRC       = 3;
   localparam int unsigned P_DST       = P_SRC + ID_BYTES;
   localparam int unsigned P_TYPE      = P_DST + ID_BYTES;
   localparam int unsigned P_LEN       = P_TYPE + 1;
   localparam int unsigned HEADER_SIZE = P_LEN + 1;

   // Fixed byte values.
   localparam logic [7:0] START_BYTE  = 8'hFF;
   localparam logic [7:0] VERSION_ONE = 8'h01;
   localparam logic [7:0] END_BYTE0   = 8'h0D;
   localparam logic [7:0] END_BYTE1   = 8'h0A;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_BAD_START   = 2'd1,
      STATUS_BAD_VERSION = 2'd2,
      STATUS_BAD_TRAILER = 2'd3
   } lfd_status_type;

   // One incoming word.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       frame_start;
   } lfd_word_type;

   // One result word.
   typedef struct packed {
      logic            data_valid;
      logic [7:0]      data_byte;
      logic            frame_done;
      lfd_status_type  status;
      logic [7:0]      seq_num;
      logic [7:0]      msg_type;
      logic [ID_W-1:0] src_id;
      logic [ID_W-1:0] dst_id;
      logic [7:0]      data_len;
   } lfd_result_type;

endpackage

/* src/lfd_in_stage.sv */
// Input register of the frame deframer: holds one accepted word.
// Depends on lfd_pkg.
module lfd_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lfd_pkg::lfd_word_type req_word,
   input  logic                 take,
   output logic                 word_valid,
   output lfd_pkg::lfd_word_type word
);
   import lfd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   lfd_word_type word_ff;
   logic         accept;

   // The register frees up whenever its word moves on.
   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= req_word;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

/* src/lfd_parser.sv */
// Frame parser: position counter, captured header and the per-word result.
// Depends on lfd_pkg and local_frame_deframer_assert.svh.
`include "local_frame_deframer_assert.svh"

module lfd_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  lfd_pkg::lfd_word_type   word,
   output lfd_pkg::lfd_result_type result
);
   import lfd_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             active_ff, active_in;
   logic             tbad_ff, tbad_in;
   logic [7:0]       seq_ff, seq_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       len_ff, len_in;
   logic [ID_W-1:0]  src_ff, src_in;
   logic [ID_W-1:0]  dst_ff, dst_in;

   logic             cur_active;
   logic [POS_W-1:0] p;
   logic [POS_W-1:0] data_end;
   logic [7:0]       b;

   // Decode one byte against the current position in the frame.
   always_comb begin
      b          = word.in_byte;
      cur_active = word.frame_start || active_ff;
      p          = word.frame_start ? '0 : pos_ff;
      tbad_in    = word.frame_start ? 1'b0 : tbad_ff;
      active_in  = cur_active;
      pos_in     = pos_ff;
      seq_in     = seq_ff;
      type_in    = type_ff;
      len_in     = len_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      data_end   = POS_W'(HEADER_SIZE) + {{(POS_W-8){1'b0}}, len_ff};

      result            = '0;
      result.status     = STATUS_OK;

      if (cur_active) begin
         if (p == POS_W'(P_START)) begin
            if (b != START_BYTE) begin
               result.frame_done = 1'b1;
               result.status     = STATUS_BAD_START;
               active_in         = 1'b0;
            end
         end else if (p == POS_W'(P_VER)) begin
            if (b != VERSION_ONE) begin
               result.frame_done = 1'b1;
               result.status     = STATUS_BAD_VERSION;
               active_in         = 1'b0;
            end
         end else if (p == POS_W'(P_SEQ)) begin
            seq_in = b;
         end else if (p >= POS_W'(P_SRC) && p < POS_W'(P_DST)) begin
            src_in = {src_ff[ID_W-9:0], b};
         end else if (p >= POS_W'(P_DST) && p < POS_W'(P_TYPE)) begin
            dst_in = {dst_ff[ID_W-9:0], b};
         end else if (p == POS_W'(P_TYPE)) begin
            type_in = b;
         end else if (p == POS_W'(P_LEN)) begin
            len_in = b;
         end else if (p < data_end) begin
            result.data_valid = 1'b1;
            result.data_byte  = b;
         end else if (p == data_end) begin
            tbad_in = (b != END_BYTE0);
         end else begin
            // Second trailer byte closes the frame.
            result.frame_done = 1'b1;
            result.status     = (tbad_in || b != END_BYTE1) ? STATUS_BAD_TRAILER
                                                           : STATUS_OK;
            active_in         = 1'b0;
         end
         pos_in = active_in ? p + POS_W'(1) : '0;
      end

      result.seq_num  = seq_in;
      result.msg_type = type_in;
      result.src_id   = src_in;
      result.dst_id   = dst_in;
      result.data_len = len_in;
   end

   // State advances once per processed word.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         active_ff <= 1'b0;
         tbad_ff   <= 1'b0;
         seq_ff    <= '0;
         type_ff   <= '0;
         len_ff    <= '0;
         src_ff    <= '0;
         dst_ff    <= '0;
      end else if (fire) begin
         pos_ff    <= pos_in;
         active_ff <= active_in;
         tbad_ff   <= tbad_in;
         seq_ff    <= seq_in;
         type_ff   <= type_in;
         len_ff    <= len_in;
         src_ff    <= src_in;
         dst_ff    <= dst_in;
      end
   end

   // The position counter rests at zero between frames.
   `LFD_ASSERT_NOW(a_idle_pos, !active_ff, pos_ff == '0, "position not zero while idle")
   // A payload word never also ends the frame.
   `LFD_ASSERT_NOW(a_data_not_done, fire && result.data_valid, !result.frame_done, "data word ends frame")
   // Ending a frame leaves the parser idle.
   `LFD_ASSERT_NEXT(a_done_idle, fire && result.frame_done, !active_ff && pos_ff == '0, "parser active after frame end")
   // A new frame always leaves the parser running or reports an error on it.
   `LFD_ASSERT_NEXT(a_start_runs, fire && word.frame_start && !result.frame_done, active_ff, "frame start did not activate parser")

endmodule

/* src/lfd_rsp_stage.sv */
// Result register of the frame deframer with its valid flag.
// Depends on lfd_pkg.
module lfd_rsp_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  lfd_pkg::lfd_result_type result_in,
   output logic                   can_load,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lfd_pkg::lfd_result_type result
);
   import lfd_pkg::*;

   logic           valid_ff, valid_in;
   lfd_result_type result_ff;

   // Space is free when empty or when the held word leaves this cycle.
   assign can_load = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign result    = result_ff;

endmodule

/* src/local_frame_deframer.sv */
// Top level of the local frame deframer: input register, parser, result register.
// Depends on lfd_pkg, lfd_in_stage, lfd_parser and lfd_rsp_stage.
//
//   channel  | handshake            | word
//   ---------+----------------------+------------------------------------------
//   req      | req_valid/req_stall  | in_byte, frame_start
//   rsp      | rsp_valid/rsp_stall  | data, done, status, captured header fields
//
// One word is taken per cycle while req is not stalled, and gives one result word;
// it passes the input register, then parse logic into the result register.
// Synchronous reset clears the parser state, header captures and both valid flags.
// A stall on rsp holds the result register; req stalls only while the input
// register is full and its word cannot move into the result register.
module local_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_data_valid,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_frame_done,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_seq_num,
   output logic [7:0]  rsp_msg_type,
   output logic [15:0] rsp_src_id,
   output logic [15:0] rsp_dst_id,
   output logic [7:0]  rsp_data_len
);
   import lfd_pkg::*;

   lfd_word_type   req_word;
   lfd_word_type   word;
   logic           word_valid;
   logic           can_load;
   logic           fire;
   lfd_result_type next_result;
   lfd_result_type result;

   assign req_word.in_byte     = req_in_byte;
   assign req_word.frame_start = req_frame_start;

   // A held word is parsed when the result register has room.
   assign fire = word_valid && can_load;

   lfd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .take       (can_load),
      .word_valid (word_valid),
      .word       (word)
   );

   lfd_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .word   (word),
      .result (next_result)
   );

   lfd_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .result_in (next_result),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .result    (result)
   );

   // Result fields to ports.
   assign rsp_data_valid = result.data_valid;
   assign rsp_data_byte  = result.data_byte;
   assign rsp_frame_done = result.frame_done;
   assign rsp_status     = result.status;
   assign rsp_seq_num    = result.seq_num;
   assign rsp_msg_type   = result.msg_type;
   assign rsp_src_id     = result.src_id;
   assign rsp_dst_id     = result.dst_id;
   assign rsp_data_len   = result.data_len;

endmodule
